@@ src/bogu_pkg.sv @@
// Package of the Bayes occupancy grid engine: operation codes, register
// indexes, fixed-point constants and payload types. Depends on nothing.
package bogu_pkg;

   typedef logic [15:0] prob_type;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_READ   = 2'd1,
      OP_SHIFT  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_CEILING = 2'd0,
      CSR_FLOOR   = 2'd1,
      CSR_BAND    = 2'd2
   } csr_index_type;

   localparam prob_type    HALF_Q16      = 16'd32768;
   localparam logic [16:0] ONE_Q16       = 17'd65536;
   localparam prob_type    CEILING_RESET = 16'd63570;
   localparam prob_type    FLOOR_RESET   = 16'd7864;
   localparam logic [14:0] BAND_RESET    = 15'd655;
   localparam logic [6:0]  EXPORT_SCALE  = 7'd100;
   localparam logic [7:0]  EXPORT_UNKNOWN = 8'hFF;

endpackage

@@ src/bogu_if.sv @@
// Channel interfaces of the occupancy grid engine: the request channel and
// the response channel. Both depend on bogu_pkg for the payload types.
interface bogu_req_if;
   import bogu_pkg::*;
   logic       valid;
   logic       ready;
   op_type     operation;
   logic [5:0] cell_x;
   logic [5:0] cell_y;
   prob_type   likelihood;
   logic signed [7:0] shift_dx;
   logic signed [7:0] shift_dy;
   modport source (output valid, operation, cell_x, cell_y, likelihood, shift_dx,
                   shift_dy, input ready);
   modport sink   (input valid, operation, cell_x, cell_y, likelihood, shift_dx,
                   shift_dy, output ready);
endinterface

interface bogu_rsp_if;
   import bogu_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   prob_type          cell_prob;
   logic signed [7:0] export_value;
   modport source (output valid, status, cell_prob, export_value, input ready);
   modport sink   (input valid, status, cell_prob, export_value, output ready);
endinterface

@@ src/bogu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bogu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ src/bayes_occupancy_grid_engine.sv @@
// Top level of the Bayes occupancy grid engine. Depends on bogu_pkg,
// bogu_req_if, bogu_rsp_if and bogu_ram.
//
// The grid lives in two RAM banks of GRID_SIZE*GRID_SIZE cells; one is active.
// A read passes through S_RDREQ, S_RD and S_OUT; an update passes through
// S_RDREQ, S_RD, S_MUL, S_DEN, S_DIV (the 17-step serial divider of the Bayes
// quotient), S_CLAMP and S_OUT. Clear rewrites the active bank one cell a
// cycle; shift copies the active bank into the other one cell a cycle and
// swaps banks. The engine is ready for the next request in the same cycle
// that the response turns valid. After reset the same clearing pass runs over
// every cell before the first request transfer is taken. One item is worked
// on at a time; a finished response waits in its output register while the
// next request is taken.
module bayes_occupancy_grid_engine #(
   parameter int GRID_SIZE = 64
) (
   input  logic              clock,
   input  logic              reset,
   bogu_req_if.sink          req_chan,
   bogu_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import bogu_pkg::*;

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(GRID_SIZE);
   localparam int SW    = ((RW > 8) ? RW : 8) + 2;
   localparam logic [RW-1:0] LAST_COORD = RW'(GRID_SIZE - 1);
   localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RDREQ, S_RD, S_MUL, S_DEN, S_DIV, S_CLAMP, S_OUT,
      S_SWEEP, S_SHIFT, S_SHIFT_END
   } state_type;

   state_type         state_ff;
   op_type            op_ff;
   prob_type          lik_ff, p_ff;
   logic [AW-1:0]     idx_ff, cnt_ff, pidx_ff;
   logic [RW-1:0]     ai_ff, bi_ff;
   logic signed [7:0] dx_ff, dy_ff;
   logic              bank_ff, out_pend_ff, status_ff;
   logic              pv_ff, pin_ff;
   logic [31:0]       num_ff;
   logic [33:0]       oth_ff;
   logic [32:0]       den_ff;
   logic [33:0]       rem_ff;
   logic [16:0]       low_ff, q_ff;
   logic [4:0]        step_ff;
   prob_type          ceil_ff, floor_ff;
   logic [14:0]       band_ff;
   logic              rsp_valid_ff, rsp_status_ff;
   prob_type          rsp_prob_ff;
   logic [7:0]        rsp_export_ff;

   logic              in_grid_in;
   logic [AW-1:0]     idx_in;
   logic signed [SW-1:0] sa_in, sb_in;
   logic              src_in;
   logic [AW-1:0]     src_idx_in;
   logic [34:0]       trial_in;
   logic [35:0]       diff_in;
   logic              geq_in;
   logic [16:0]       c1_in;
   prob_type          clamp_in;
   logic [16:0]       band_lo_in, band_hi_in;
   logic [22:0]       scaled_in;
   logic [7:0]        export_in;
   logic              we0, we1, wr_en_in;
   logic [AW-1:0]     waddr, raddr;
   prob_type          wdata, rdata0, rdata1, rdata;

   assign in_grid_in = (32'(req_chan.cell_x) < GRID_SIZE) &&
                       (32'(req_chan.cell_y) < GRID_SIZE);
   assign idx_in = AW'(32'(req_chan.cell_x) * GRID_SIZE + 32'(req_chan.cell_y));

   assign sa_in  = $signed({{(SW-RW){1'b0}}, ai_ff}) + $signed({{(SW-8){dx_ff[7]}}, dx_ff});
   assign sb_in  = $signed({{(SW-RW){1'b0}}, bi_ff}) + $signed({{(SW-8){dy_ff[7]}}, dy_ff});
   assign src_in = !sa_in[SW-1] && !sb_in[SW-1] &&
                   (sa_in < $signed(SW'(GRID_SIZE))) && (sb_in < $signed(SW'(GRID_SIZE)));
   assign src_idx_in = AW'(32'(sa_in[RW-1:0]) * GRID_SIZE + 32'(sb_in[RW-1:0]));

   assign trial_in = {rem_ff, low_ff[16]};
   assign diff_in  = {1'b0, trial_in} - {3'b000, den_ff};
   assign geq_in   = !diff_in[35];

   assign c1_in    = (q_ff > {1'b0, ceil_ff}) ? {1'b0, ceil_ff} : q_ff;
   assign clamp_in = (c1_in < {1'b0, floor_ff}) ? floor_ff : c1_in[15:0];

   assign band_lo_in = {1'b0, HALF_Q16} - {2'b00, band_ff};
   assign band_hi_in = {1'b0, HALF_Q16} + {2'b00, band_ff};
   assign scaled_in  = p_ff * EXPORT_SCALE;
   always_comb begin
      if (({1'b0, p_ff} > band_lo_in) && ({1'b0, p_ff} < band_hi_in)) begin
         export_in = EXPORT_UNKNOWN;
      end else if (p_ff < HALF_Q16) begin
         export_in = 8'd0;
      end else begin
         export_in = {1'b0, scaled_in[22:16]};
      end
   end

   always_comb begin
      wr_en_in = 1'b0;
      we0      = 1'b0;
      we1      = 1'b0;
      waddr    = idx_ff;
      wdata    = HALF_Q16;
      raddr    = idx_ff;
      if (state_ff == S_SHIFT) begin
         raddr = src_idx_in;
      end
      if (pv_ff) begin
         waddr = pidx_ff;
         wdata = pin_ff ? rdata : HALF_Q16;
         we0   = bank_ff;
         we1   = !bank_ff;
      end else begin
         if (state_ff == S_SWEEP) begin
            waddr    = cnt_ff;
            wr_en_in = 1'b1;
         end else if (state_ff == S_CLAMP && den_ff != 33'd0) begin
            wdata    = clamp_in;
            wr_en_in = 1'b1;
         end
         we0 = wr_en_in && !bank_ff;
         we1 = wr_en_in && bank_ff;
      end
   end

   assign rdata = bank_ff ? rdata1 : rdata0;

   bogu_ram #(.WIDTH(16), .DEPTH(CELLS)) u_bank0 (
      .clock(clock), .wr_en(we0), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata0)
   );
   bogu_ram #(.WIDTH(16), .DEPTH(CELLS)) u_bank1 (
      .clock(clock), .wr_en(we1), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata1)
   );

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.cell_prob    = rsp_prob_ff;
   assign rsp_chan.export_value = $signed(rsp_export_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         cnt_ff       <= '0;
         bank_ff      <= 1'b0;
         out_pend_ff  <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ceil_ff      <= CEILING_RESET;
         floor_ff     <= FLOOR_RESET;
         band_ff      <= BAND_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_CEILING: ceil_ff  <= csr_wdata;
               CSR_FLOOR:   floor_ff <= csr_wdata;
               CSR_BAND:    band_ff  <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         pv_ff   <= (state_ff == S_SHIFT);
         pin_ff  <= src_in;
         pidx_ff <= cnt_ff;
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  op_ff     <= req_chan.operation;
                  lik_ff    <= req_chan.likelihood;
                  dx_ff     <= req_chan.shift_dx;
                  dy_ff     <= req_chan.shift_dy;
                  idx_ff    <= idx_in;
                  cnt_ff    <= '0;
                  ai_ff     <= '0;
                  bi_ff     <= '0;
                  p_ff      <= '0;
                  status_ff <= 1'b0;
                  case (req_chan.operation)
                     OP_UPDATE, OP_READ: begin
                        if (in_grid_in) begin
                           state_ff <= S_RDREQ;
                        end else begin
                           status_ff <= 1'b1;
                           state_ff  <= S_OUT;
                        end
                     end
                     OP_SHIFT: state_ff <= S_SHIFT;
                     default: begin
                        out_pend_ff <= 1'b1;
                        state_ff    <= S_SWEEP;
                     end
                  endcase
               end
            end
            S_RDREQ: state_ff <= S_RD;
            S_RD: begin
               p_ff     <= rdata;
               state_ff <= (op_ff == OP_READ) ? S_OUT : S_MUL;
            end
            S_MUL: begin
               num_ff   <= p_ff * lik_ff;
               oth_ff   <= (ONE_Q16 - {1'b0, p_ff}) * (ONE_Q16 - {1'b0, lik_ff});
               state_ff <= S_DEN;
            end
            S_DEN: begin
               den_ff   <= {1'b0, num_ff} + oth_ff[32:0];
               rem_ff   <= {3'b000, num_ff[31:1]};
               low_ff   <= {num_ff[0], 16'd0};
               q_ff     <= '0;
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff   <= geq_in ? diff_in[33:0] : trial_in[33:0];
               low_ff   <= {low_ff[15:0], 1'b0};
               q_ff     <= {q_ff[15:0], geq_in};
               step_ff  <= step_ff + 5'd1;
               if (step_ff == 5'd16) begin
                  state_ff <= S_CLAMP;
               end
            end
            S_CLAMP: begin
               if (den_ff != 33'd0) begin
                  p_ff <= clamp_in;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_prob_ff   <= p_ff;
                  rsp_export_ff <= export_in;
                  state_ff      <= S_IDLE;
               end
            end
            S_SWEEP: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (cnt_ff == LAST_CELL) begin
                  out_pend_ff <= 1'b0;
                  state_ff    <= out_pend_ff ? S_OUT : S_IDLE;
               end
            end
            S_SHIFT: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (bi_ff == LAST_COORD) begin
                  bi_ff <= '0;
                  ai_ff <= ai_ff + RW'(1);
               end else begin
                  bi_ff <= bi_ff + RW'(1);
               end
               if (cnt_ff == LAST_CELL) begin
                  state_ff <= S_SHIFT_END;
               end
            end
            S_SHIFT_END: begin
               bank_ff  <= !bank_ff;
               state_ff <= S_OUT;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
      else $error("request transfer did not leave idle");
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_prob_ff == 16'd0 && rsp_export_ff == 8'd0))
      else $error("skipped cell gave a non-zero response");
   a_no_double_write: assert property (@(posedge clock) disable iff (reset)
      !(we0 && we1))
      else $error("both banks written at once");
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (step_ff <= 5'd16))
      else $error("divider ran past its last step");
`endif

endmodule

@@ test/bayes_occupancy_grid_engine_test.sv @@
// Testbench of the Bayes occupancy grid engine: random and directed cell updates, reads,
// shifts and clears, checked against a predictor of the grid held in the bench.
// Depends on bogu_pkg, bogu_req_if, bogu_rsp_if and bayes_occupancy_grid_engine.
module bayes_occupancy_grid_engine_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bogu_pkg::*;

   localparam int GRID = 64;
   localparam int CELLS = GRID * GRID;

   typedef struct {
      op_type            operation;
      logic [5:0]        cell_x;
      logic [5:0]        cell_y;
      prob_type          likelihood;
      logic signed [7:0] shift_dx;
      logic signed [7:0] shift_dy;
   } grid_request;

   typedef struct {
      logic              status;
      prob_type          cell_prob;
      logic signed [7:0] export_value;
   } grid_response;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_CEILING;
   logic [15:0] csr_wdata = '0;

   bogu_req_if req_chan();
   bogu_rsp_if rsp_chan();

   bayes_occupancy_grid_engine #(.GRID_SIZE(GRID)) DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   grid_request  pending_requests[$];
   grid_response expected_responses[$];
   prob_type     grid_cells[CELLS];
   prob_type     ceiling_value = CEILING_RESET;
   prob_type     floor_value = FLOOR_RESET;
   logic [14:0]  band_value = BAND_RESET;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;
   int           mismatch_count = 0;
   logic         request_taken = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic signed [7:0] export_of_prob(prob_type p);
      int pv;
      int bv;
      logic [23:0] scaled;
      pv = p;
      bv = band_value;
      if (pv > 32768 - bv && pv < 32768 + bv) return EXPORT_UNKNOWN;
      if (p < HALF_Q16) return 8'sd0;
      scaled = p * 24'd100;
      return scaled[23:16];
   endfunction

   function automatic grid_response predict_grid_op(grid_request r);
      grid_response res;
      prob_type shifted[CELLS];
      int idx;
      int sa;
      int sb;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] quot;
      res.status = 1'b0;
      res.cell_prob = '0;
      res.export_value = '0;
      case (r.operation)
         OP_UPDATE, OP_READ: begin
            if (r.cell_x >= GRID || r.cell_y >= GRID) begin
               res.status = 1'b1;
               return res;
            end
            idx = r.cell_x * GRID + r.cell_y;
            if (r.operation == OP_UPDATE) begin
               num = 64'(grid_cells[idx]) * 64'(r.likelihood);
               den = num + (64'd65536 - grid_cells[idx]) * (64'd65536 - r.likelihood);
               if (den != 0) begin
                  quot = (num << 16) / den;
                  if (quot > ceiling_value) quot = ceiling_value;
                  if (quot < floor_value) quot = floor_value;
                  grid_cells[idx] = quot[15:0];
               end
            end
            res.cell_prob = grid_cells[idx];
            res.export_value = export_of_prob(grid_cells[idx]);
         end
         OP_SHIFT: begin
            for (int a = 0; a < GRID; a++) begin
               for (int b = 0; b < GRID; b++) begin
                  sa = a + int'(r.shift_dx);
                  sb = b + int'(r.shift_dy);
                  if (sa >= 0 && sa < GRID && sb >= 0 && sb < GRID)
                     shifted[a * GRID + b] = grid_cells[sa * GRID + sb];
                  else
                     shifted[a * GRID + b] = HALF_Q16;
               end
            end
            grid_cells = shifted;
         end
         default: begin
            foreach (grid_cells[i]) grid_cells[i] = HALF_Q16;
         end
      endcase
      return res;
   endfunction

   // Requests are presented at the falling edge and held until a transfer takes them.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || request_taken) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.operation <= pending_requests[0].operation;
            req_chan.cell_x <= pending_requests[0].cell_x;
            req_chan.cell_y <= pending_requests[0].cell_y;
            req_chan.likelihood <= pending_requests[0].likelihood;
            req_chan.shift_dx <= pending_requests[0].shift_dx;
            req_chan.shift_dy <= pending_requests[0].shift_dy;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
      request_taken <= 1'b0;
   end

   always @(posedge clock) begin
      grid_request  r;
      grid_response got;
      grid_response want;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r = pending_requests.pop_front();
         expected_responses.insert(expected_responses.size(), predict_grid_op(r));
         request_taken <= 1'b1;
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.status = rsp_chan.status;
         got.cell_prob = rsp_chan.cell_prob;
         got.export_value = rsp_chan.export_value;
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: status %0d prob %0d export %0d",
                        got.status, got.cell_prob, got.export_value);
         end else begin
            want = expected_responses.pop_front();
            if (got.status !== want.status || got.cell_prob !== want.cell_prob ||
                got.export_value !== want.export_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected status %0d prob %0d export %0d, got %0d %0d %0d",
                           want.status, want.cell_prob, want.export_value,
                           got.status, got.cell_prob, got.export_value);
            end
         end
      end
   end

   task automatic add_request(op_type op, int x, int y, int lik, int dx, int dy);
      grid_request r;
      r.operation = op;
      r.cell_x = 6'(x);
      r.cell_y = 6'(y);
      r.likelihood = 16'(lik);
      r.shift_dx = 8'(dx);
      r.shift_dy = 8'(dy);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic write_register(csr_index_type index, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_CEILING: ceiling_value = value;
         CSR_FLOOR:   floor_value = value;
         default:     band_value = value[14:0];
      endcase
   endtask

   task automatic add_random_request();
      int pick;
      int x;
      int y;
      pick = $urandom_range(99);
      x = ($urandom_range(1)) ? $urandom_range(3) : $urandom_range(63);
      y = ($urandom_range(1)) ? $urandom_range(3) : $urandom_range(63);
      if (pick < 50)
         add_request(OP_UPDATE, x, y, $urandom_range(65535), $urandom_range(255),
                     $urandom_range(255));
      else if (pick < 96)
         add_request(OP_READ, x, y, $urandom_range(65535), $urandom_range(255),
                     $urandom_range(255));
      else if (pick < 99)
         add_request(OP_SHIFT, x, y, $urandom_range(65535),
                     ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4) - 2,
                     ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4) - 2);
      else
         add_request(OP_CLEAR, x, y, $urandom_range(65535), $urandom_range(255),
                     $urandom_range(255));
   endtask

   task automatic wait_until_idle();
      while (pending_requests.size() > 0 || expected_responses.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      int idle_pct[4] = '{0, 50, 0, 8};
      int stall_pct[4] = '{0, 0, 50, 8};
      req_chan.valid = 1'b0;
      req_chan.operation = OP_READ;
      req_chan.cell_x = '0;
      req_chan.cell_y = '0;
      req_chan.likelihood = '0;
      req_chan.shift_dx = '0;
      req_chan.shift_dy = '0;
      rsp_chan.ready = 1'b0;
      foreach (grid_cells[i]) grid_cells[i] = HALF_Q16;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_pct[phase];
         receiver_stall_pct = stall_pct[phase];
         case (phase)
            1: begin
               write_register(CSR_CEILING, 16'hFFFF);
               write_register(CSR_FLOOR, 16'h0000);
               write_register(CSR_BAND, 16'h0000);
            end
            2: begin
               // The floor lies above the ceiling, so every update lands on the floor.
               write_register(CSR_CEILING, 16'd1000);
               write_register(CSR_FLOOR, 16'd60000);
               write_register(CSR_BAND, 16'h7FFF);
            end
            3: begin
               write_register(CSR_CEILING, 16'($urandom_range(65535, 32768)));
               write_register(CSR_FLOOR, 16'($urandom_range(32767)));
               write_register(CSR_BAND, 16'($urandom_range(2000)));
            end
            default: ;
         endcase
         add_request(OP_READ, 0, 0, 0, 0, 0);
         add_request(OP_READ, 63, 63, 65535, -1, -1);
         add_request(OP_UPDATE, 0, 0, 65535, 0, 0);
         add_request(OP_UPDATE, 0, 0, 65535, 0, 0);
         add_request(OP_UPDATE, 63, 0, 0, 0, 0);
         add_request(OP_UPDATE, 0, 63, 1, 0, 0);
         add_request(OP_UPDATE, 1, 1, 32768, 0, 0);
         add_request(OP_UPDATE, 1, 2, 33000, 0, 0);
         add_request(OP_UPDATE, 1, 3, 32500, 0, 0);
         add_request(OP_SHIFT, 0, 0, 0, 1, 0);
         add_request(OP_READ, 0, 0, 0, 0, 0);
         add_request(OP_READ, 1, 0, 0, 0, 0);
         add_request(OP_SHIFT, 0, 0, 0, -1, -1);
         add_request(OP_READ, 1, 1, 0, 0, 0);
         add_request(OP_SHIFT, 0, 0, 0, 127, 0);
         add_request(OP_SHIFT, 0, 0, 0, -128, 64);
         add_request(OP_UPDATE, 2, 2, 50000, 0, 0);
         add_request(OP_CLEAR, 63, 63, 65535, 127, -128);
         add_request(OP_READ, 2, 2, 0, 0, 0);
         for (int i = 0; i < 280; i++) add_random_request();
         wait_until_idle();
      end
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
src/bogu_pkg.sv
src/bogu_if.sv
src/bogu_ram.sv
src/bayes_occupancy_grid_engine.sv
test/bayes_occupancy_grid_engine_test.sv
